FILE: rtl/core/mvhi_pkg.sv
// shared types and constants of the multi-value hash index
`timescale 1ns / 1ps
package mvhi_pkg;

  localparam int unsigned SIZE_W = 17;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd65536;
  localparam logic [31:0] EMPTY_POS = 32'hffff_ffff;
  localparam logic [63:0] FMIX_C1 = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ce_b9fe_1a85_ec53;
  localparam int unsigned FMIX_SHIFT = 33;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_FAILED    = 3'd3,
    ST_BROKEN    = 3'd4,
    ST_CORRUPT   = 3'd5,
    ST_TRUNCATED = 3'd6
  } status_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] pos;
    logic        last;
  } entry_t;

endpackage

FILE: rtl/core/multi_value_hash_index.sv
// multi-value hash index: open-addressed key to positions table
// processing: hash, then modulo, then a read and an evaluation per probed slot and an output per
// result item, plus another modulo if the probe wraps
// throughput: one item at a time, set by the serial modulo unit and the
// shared read/write address of the slot memory
// reset: clearing pass over every slot of the slot memory, input held off
`timescale 1ns / 1ps
module multi_value_hash_index #(
  parameter int unsigned TABLE_DEPTH = 65536,
  parameter int unsigned PROBE_LIMIT = 8,
  parameter int unsigned MAX_HITS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  // item in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // key [63:0], position [95:64]
  input  logic        s_axis_tuser,  // kind
  // result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // slot_index [15:0], stored_position [47:16],
                                     // status [50:48], zero fill
  output logic        m_axis_tlast,  // last
  // table size register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data       // table_size
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  // probe sums need room for the size plus the largest quadratic step
  localparam int unsigned PW = ((AW > mvhi_pkg::SIZE_W) ? AW : mvhi_pkg::SIZE_W) + 1;
  localparam int unsigned NW = $clog2(PROBE_LIMIT + 2);
  localparam int unsigned HW = $clog2(MAX_HITS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_DIV, S_READ, S_EVAL, S_OUT, S_WDIV
  } state_t;

  state_t                      state;
  logic [mvhi_pkg::SIZE_W-1:0] table_size;
  logic [mvhi_pkg::SIZE_W-1:0] size_use;
  logic [mvhi_pkg::SIZE_W-1:0] size_r;
  logic                        kind_r;
  logic [63:0]                 key_r;
  logic [31:0]                 pos_r;
  logic [AW-1:0]               idx;
  logic [NW-1:0]               n;
  logic                        wrapped;
  logic [HW-1:0]               hits;
  logic [PW-1:0]               wrap_val;
  logic                        mod_pend;
  logic                        res_end;

  // slot memory and the two serial units
  logic                        tbl_ready;
  logic                        rd_en;
  mvhi_pkg::entry_t            e;
  logic                        wr_en;
  mvhi_pkg::entry_t            wr_data;
  logic                        hash_start;
  logic                        hash_done;
  logic [63:0]                 hash;
  logic                        div_start;
  logic [63:0]                 div_dividend;
  logic                        div_done;
  logic [mvhi_pkg::SIZE_W-1:0] div_rem;

  // result register
  logic [15:0]                 o_slot;
  logic [31:0]                 o_pos;
  mvhi_pkg::status_t           o_status;

  // probe step arithmetic
  logic [2*NW-1:0]             nsq;
  logic                        quad;
  logic [PW-1:0]               nxt;
  logic                        over;
  logic                        adv_ok;
  logic [NW-1:0]               n_next;
  logic                        key_eq;
  logic                        empty;
  logic [HW-1:0]               hits_inc;

  mvhi_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (e),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_data),
    .ready   (tbl_ready)
  );

  mvhi_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key_r),
    .done  (hash_done),
    .hash  (hash)
  );

  mvhi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (size_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  // size in use: zero reads as one, anything above the depth as the depth
  always_comb begin
    size_use = table_size;
    if (table_size == '0) begin
      size_use = mvhi_pkg::SIZE_W'(1);
    end else if (32'(table_size) > 32'(TABLE_DEPTH)) begin
      size_use = mvhi_pkg::SIZE_W'(TABLE_DEPTH);
    end
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE) && tbl_ready;
  assign rd_en         = (state == S_READ);
  assign m_axis_tdata  = {5'd0, o_status, o_pos, o_slot};

  // quadratic steps first, unit steps after the probe limit
  assign quad     = (32'(n) <= 32'(PROBE_LIMIT));
  assign nsq      = (2*NW)'(n) * (2*NW)'(n);
  assign nxt      = PW'(idx) + (quad ? PW'(nsq) : PW'(1));
  assign over     = (nxt >= PW'(size_r));
  assign adv_ok   = !over || !wrapped;
  assign n_next   = quad ? n + NW'(1) : n;
  assign key_eq   = (e.key == key_r);
  assign empty    = (e.pos == mvhi_pkg::EMPTY_POS);
  assign hits_inc = hits + HW'(1);

  // insert writes: clear the last flag of a same-key entry, or fill an empty slot whose key is zero
  always_comb begin
    wr_en   = 1'b0;
    wr_data = e;
    if (state == S_EVAL && kind_r == mvhi_pkg::KIND_INSERT) begin
      if (!empty) begin
        if (key_eq && e.pos != pos_r) begin
          wr_en        = 1'b1;
          wr_data.last = 1'b0;
        end
      end else if (e.key == 64'd0) begin
        wr_en       = 1'b1;
        wr_data.key = key_r;
        wr_data.pos = pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      table_size    <= mvhi_pkg::SIZE_RESET;
      m_axis_tvalid <= 1'b0;
      hash_start    <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      hash_start <= 1'b0;
      div_start  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind_r   <= s_axis_tuser;
            key_r    <= s_axis_tdata[63:0];
            pos_r    <= s_axis_tdata[95:64];
            size_r   <= size_use;
            n        <= NW'(1);
            wrapped  <= 1'b0;
            hits     <= '0;
            mod_pend <= 1'b0;
            if (s_axis_tuser == mvhi_pkg::KIND_INSERT &&
                s_axis_tdata[95:64] == mvhi_pkg::EMPTY_POS) begin
              // the empty mark cannot be stored
              o_slot        <= 16'd0;
              o_pos         <= 32'd0;
              o_status      <= mvhi_pkg::ST_FAILED;
              m_axis_tlast  <= 1'b1;
              res_end       <= 1'b1;
              m_axis_tvalid <= 1'b1;
              state         <= S_OUT;
            end else begin
              hash_start <= 1'b1;
              state      <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            div_dividend <= hash;
            div_start    <= 1'b1;
            state        <= S_DIV;
          end
        end
        S_DIV, S_WDIV: begin
          if (div_done) begin
            idx   <= AW'(div_rem);
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          // defaults for a final result
          m_axis_tlast <= 1'b1;
          res_end      <= 1'b1;
          o_slot       <= 16'd0;
          o_pos        <= 32'd0;
          if (kind_r == mvhi_pkg::KIND_INSERT) begin
            if (!empty) begin
              if (key_eq && e.pos == pos_r) begin
                o_slot        <= 16'(idx);
                o_pos         <= pos_r;
                o_status      <= mvhi_pkg::ST_DUPLICATE;
                m_axis_tvalid <= 1'b1;
                state         <= S_OUT;
              end else if (!adv_ok) begin
                o_status      <= mvhi_pkg::ST_FAILED;
                m_axis_tvalid <= 1'b1;
                state         <= S_OUT;
              end else begin
                // keep probing
                n <= n_next;
                if (over) begin
                  wrapped      <= 1'b1;
                  div_dividend <= 64'(nxt);
                  div_start    <= 1'b1;
                  state        <= S_WDIV;
                end else begin
                  idx   <= AW'(nxt);
                  state <= S_READ;
                end
              end
            end else if (e.key != 64'd0) begin
              o_status      <= mvhi_pkg::ST_FAILED;
              m_axis_tvalid <= 1'b1;
              state         <= S_OUT;
            end else begin
              o_slot        <= 16'(idx);
              o_pos         <= pos_r;
              o_status      <= mvhi_pkg::ST_HIT;
              m_axis_tvalid <= 1'b1;
              state         <= S_OUT;
            end
          end else begin
            if (!key_eq && !empty && adv_ok) begin
              // skip a foreign entry
              n <= n_next;
              if (over) begin
                wrapped      <= 1'b1;
                div_dividend <= 64'(nxt);
                div_start    <= 1'b1;
                state        <= S_WDIV;
              end else begin
                idx   <= AW'(nxt);
                state <= S_READ;
              end
            end else if (!key_eq) begin
              // end of probe without a match
              o_status      <= (hits == '0) ? mvhi_pkg::ST_ABSENT : mvhi_pkg::ST_BROKEN;
              m_axis_tvalid <= 1'b1;
              state         <= S_OUT;
            end else if (empty) begin
              // matching key in an empty slot
              o_slot        <= 16'(idx);
              o_pos         <= mvhi_pkg::EMPTY_POS;
              o_status      <= (key_r == 64'd0) ? mvhi_pkg::ST_BROKEN
                                                : mvhi_pkg::ST_CORRUPT;
              m_axis_tvalid <= 1'b1;
              state         <= S_OUT;
            end else begin
              // hit
              hits          <= hits_inc;
              o_slot        <= 16'(idx);
              o_pos         <= e.pos;
              m_axis_tvalid <= 1'b1;
              state         <= S_OUT;
              if (e.last || !adv_ok) begin
                o_status <= mvhi_pkg::ST_HIT;
              end else if (32'(hits_inc) >= 32'(MAX_HITS)) begin
                o_status <= mvhi_pkg::ST_TRUNCATED;
              end else begin
                o_status     <= mvhi_pkg::ST_HIT;
                m_axis_tlast <= 1'b0;
                res_end      <= 1'b0;
                n            <= n_next;
                if (over) begin
                  wrapped  <= 1'b1;
                  wrap_val <= nxt;
                  mod_pend <= 1'b1;
                end else begin
                  idx      <= AW'(nxt);
                  mod_pend <= 1'b0;
                end
              end
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (res_end) begin
              state <= S_IDLE;
            end else if (mod_pend) begin
              mod_pend     <= 1'b0;
              div_dividend <= 64'(wrap_val);
              div_start    <= 1'b1;
              state        <= S_WDIV;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/mvhi_hash.sv
// multi-cycle 64-bit murmur finalizer built on one 32x32 multiplier
`timescale 1ns / 1ps
module mvhi_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output logic [63:0] hash
);

  logic [63:0] h;
  logic [63:0] acc;
  logic [2:0]  cnt;
  logic        busy;
  logic [63:0] c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // cnt[2] picks the round, cnt[1:0] walks the partial products
  assign c     = cnt[2] ? mvhi_pkg::FMIX_C2 : mvhi_pkg::FMIX_C1;
  assign mul_a = (cnt[1:0] == 2'd2) ? h[63:32] : h[31:0];
  assign mul_b = (cnt[1:0] == 2'd1) ? c[63:32] : c[31:0];
  assign prod  = mul_a * mul_b;
  assign hash  = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        h    <= key ^ (key >> mvhi_pkg::FMIX_SHIFT);
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        case (cnt[1:0])
          2'd0: acc <= prod;
          2'd1: acc <= acc + {prod[31:0], 32'd0};
          2'd2: acc <= acc + {prod[31:0], 32'd0};
          default: begin
            h <= acc ^ (acc >> mvhi_pkg::FMIX_SHIFT);
            if (cnt[2]) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/mvhi_div.sv
// bit-serial remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
module mvhi_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 dividend,
  input  logic [mvhi_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [mvhi_pkg::SIZE_W-1:0] rem
);

  logic [63:0]               q;
  logic [mvhi_pkg::SIZE_W-1:0] d;
  logic [5:0]                cnt;
  logic                      busy;
  logic [mvhi_pkg::SIZE_W:0] trial;

  assign trial = {rem, q[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        d    <= divisor;
        rem  <= '0;
        cnt  <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        q   <= {q[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (trial >= {1'b0, d}) begin
          rem <= mvhi_pkg::SIZE_W'(trial - {1'b0, d});
        end else begin
          rem <= trial[mvhi_pkg::SIZE_W-1:0];
        end
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/mvhi_table.sv
// slot memory with registered read and a clearing pass after reset
`timescale 1ns / 1ps
module mvhi_table #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output mvhi_pkg::entry_t         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  mvhi_pkg::entry_t         wr_data,
  output logic                     ready
);

  localparam int unsigned AW = $clog2(DEPTH);

  mvhi_pkg::entry_t mem [DEPTH];
  logic             clearing;
  logic [AW-1:0]    clr_addr;
  logic             we;
  logic [AW-1:0]    wa;
  mvhi_pkg::entry_t wd;

  always_comb begin
    we = wr_en;
    wa = wr_addr;
    wd = wr_data;
    if (clearing) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '{key: 64'd0, pos: mvhi_pkg::EMPTY_POS, last: 1'b1};
    end
  end

  assign ready = !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
